// ===== rtl/core/sltok_pkg.sv =====
// Shared types and constants for the tokenizer core.
package sltok_pkg;

  localparam logic [1:0] REC_TEXT  = 2'd0;
  localparam logic [1:0] REC_END   = 2'd1;
  localparam logic [1:0] REC_ERROR = 2'd2;

  localparam logic [5:0] TK_IDENT   = 6'd0;
  localparam logic [5:0] TK_INT     = 6'd1;
  localparam logic [5:0] TK_FLOAT   = 6'd2;
  localparam logic [5:0] TK_STRING  = 6'd3;
  localparam logic [5:0] TK_CHAR    = 6'd4;
  localparam logic [5:0] TK_EOF     = 6'd5;
  localparam logic [5:0] TK_UNKNOWN = 6'd6;
  localparam logic [5:0] TK_TABLE   = 6'd7;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_COMMENT  = 3'd1;
  localparam logic [2:0] ERR_STRING   = 3'd2;
  localparam logic [2:0] ERR_LONGCHAR = 3'd3;
  localparam logic [2:0] ERR_TWODOTS  = 3'd4;
  localparam logic [2:0] ERR_BADCHAR  = 3'd5;
  localparam logic [2:0] ERR_INTERP   = 3'd6;

  localparam int TableSize = 51;
  localparam int TableLen  = 6;

  // one input item as it arrives on the source channel
  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } src_item_t;

  // one input item after the front end has classified it
  typedef enum logic [3:0] {
    CL_OTHER = 4'd0, CL_BLANK = 4'd1, CL_NEWLINE = 4'd2, CL_BAR = 4'd3,
    CL_QUOTE = 4'd4, CL_OPEN = 4'd5, CL_CLOSE = 4'd6, CL_SINGLE = 4'd7,
    CL_ARITH = 4'd8, CL_ALPHA = 4'd9, CL_DIGIT = 4'd10, CL_DOT = 4'd11,
    CL_EQUAL = 4'd12, CL_BSLASH = 4'd13
  } char_class_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        eoi;
    char_class_t cls;
  } front_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [7:0]  text_byte;
    logic [5:0]  token_kind;
    logic [15:0] line_number;
    logic [11:0] char_count;
    logic [2:0]  error_code;
    logic        last_of_run;
  } result_t;

  typedef enum logic [7:0] {
    M_IDLE    = 8'b0000_0001,
    M_COMMENT = 8'b0000_0010,
    M_WORD    = 8'b0000_0100,
    M_NUMBER  = 8'b0000_1000,
    M_OP      = 8'b0001_0000,
    M_STRING  = 8'b0010_0000,
    M_ESCAPE  = 8'b0100_0000,
    M_RESUME  = 8'b1000_0000
  } scan_mode_t;

  typedef logic [TableLen*8-1:0] entry_text_t;

  function automatic entry_text_t tstr(input int idx);
    case (idx)
      0: tstr = "create"; 1: tstr = "as"; 2: tstr = "start"; 3: tstr = "end";
      4: tstr = "if"; 5: tstr = "else"; 6: tstr = "while"; 7: tstr = "stop";
      8: tstr = "skip"; 9: tstr = "say"; 10: tstr = "with"; 11: tstr = "return";
      12: tstr = "in"; 13: tstr = "true"; 14: tstr = "false"; 15: tstr = "repeat";
      16: tstr = "to"; 17: tstr = "step"; 18: tstr = "on"; 19: tstr = "than";
      20: tstr = "int"; 21: tstr = "float"; 22: tstr = "char"; 23: tstr = "list";
      24: tstr = "string"; 25: tstr = "bool"; 26: tstr = "void"; 27: tstr = "is";
      28: tstr = "not"; 29: tstr = "more"; 30: tstr = "less"; 31: tstr = "and";
      32: tstr = "or"; 33: tstr = "="; 34: tstr = "+"; 35: tstr = "-";
      36: tstr = "*"; 37: tstr = "/"; 38: tstr = "%"; 39: tstr = "+=";
      40: tstr = "-="; 41: tstr = "*="; 42: tstr = "/="; 43: tstr = "%=";
      44: tstr = "("; 45: tstr = ")"; 46: tstr = "["; 47: tstr = "]";
      48: tstr = entry_text_t'(8'h0a); 49: tstr = ":"; 50: tstr = ",";
      default: tstr = '0;
    endcase
  endfunction

  function automatic int tlen(input int idx);
    entry_text_t s;
    int n;
    s = tstr(idx);
    n = 0;
    for (int i = 0; i < TableLen; i++) if (s[i*8 +: 8] != 8'h00) n = i + 1;
    tlen = n;
  endfunction

  // strings are right-aligned: first character in the highest used byte
  function automatic logic [7:0] tchar(input int idx, input int pos);
    int n;
    n = tlen(idx);
    tchar = tstr(idx)[(n-1-pos)*8 +: 8];
  endfunction

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r = CL_OTHER;
    if (c == " " || c == 8'h09) r = CL_BLANK;
    else if (c == 8'h0a) r = CL_NEWLINE;
    else if (c == "|") r = CL_BAR;
    else if (c == "\"") r = CL_QUOTE;
    else if (c == "'") r = CL_SINGLE;
    else if (c == "(" || c == "[") r = CL_OPEN;
    else if (c == ")" || c == "]") r = CL_CLOSE;
    else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "%") r = CL_ARITH;
    else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") r = CL_ALPHA;
    else if (c >= "0" && c <= "9") r = CL_DIGIT;
    else if (c == ".") r = CL_DOT;
    else if (c == "=") r = CL_EQUAL;
    else if (c == "\\") r = CL_BSLASH;
    classify = r;
  endfunction

endpackage

// ===== rtl/core/sltok_stream_if.sv =====
// Valid/ready channel carrying one payload.
interface sltok_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/sltok_front.sv =====
// Front end: accepts source items, classifies them, feeds a two-entry queue.
module sltok_front (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] in_byte,
  input  logic       in_eoi,
  input  logic       in_valid,
  output logic       in_ready,
  output sltok_pkg::front_item_t q_item,
  output logic       q_valid,
  input  logic       q_take
);
  import sltok_pkg::*;

  front_item_t slot [2];
  logic        rd_ptr, wr_ptr;
  logic [1:0]  count;
  logic        push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= '{ch: in_byte, eoi: in_eoi, cls: classify(in_byte)};
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_take};
    end
  end
endmodule

// ===== rtl/core/sltok_back.sv =====
// Back end: scanner state machine; up to three records per item, one per ready cycle.
module sltok_back #(
  parameter int KEYWORD_MAX_LEN = 6,
  parameter int LENGTH_BITS     = 12,
  parameter int LINE_BITS       = 16,
  parameter int DEPTH_BITS      = 8
) (
  input  logic clk,
  input  logic rst,
  input  sltok_pkg::front_item_t q_item,
  input  logic       q_valid,
  output logic       q_take,
  output sltok_pkg::result_t res,
  output logic       res_valid,
  input  logic       res_ready
);
  import sltok_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LenMax   = '1;
  localparam logic [LINE_BITS-1:0]   LineMax  = '1;
  localparam logic [DEPTH_BITS-1:0]  DepthMax = '1;
  localparam int PB = $clog2(KEYWORD_MAX_LEN);

  scan_mode_t scan_mode, scan_mode_next;
  logic [7:0] pending_operator, pending_operator_next;
  logic [LINE_BITS-1:0] line_count, line_count_next;
  logic [DEPTH_BITS-1:0] nesting_depth, nesting_depth_next;
  logic [DEPTH_BITS-1:0] interpolation_depth, interpolation_depth_next;
  logic in_interpolation, in_interpolation_next;
  logic [1:0] open_quote, open_quote_next;
  logic [7:0] word_prefix [KEYWORD_MAX_LEN];
  logic [LENGTH_BITS-1:0] length_count, length_count_next;
  logic seen_dot, seen_dot_next;
  logic halted, halted_next;

  // per-item record list built combinationally, drained one per cycle with res_ready
  typedef struct packed {
    logic [1:0]  rk;
    logic [7:0]  tb;
    logic [5:0]  tk;
    logic [11:0] len;
    logic [2:0]  err;
    logic        sel_line; // 1: use line after update
  } rec_t;

  rec_t rec [3];
  logic [1:0] nrec;
  logic       wp_we;
  logic [PB-1:0] wp_idx;
  logic [LINE_BITS-1:0] line_pre;

  // drain registers
  rec_t held [3];
  logic [LINE_BITS-1:0] held_line_pre, held_line_post;
  logic [1:0] held_n, held_pos;
  logic busy;

  logic [11:0] len_sat;

  function automatic logic [11:0] out_len(input logic [LENGTH_BITS-1:0] l);
    logic [31:0] w;
    w = 32'(l);
    out_len = w[11:0];
  endfunction

  function automatic logic [5:0] lookup_op(input logic [7:0] c, input logic eq);
    logic [5:0] k;
    k = TK_UNKNOWN;
    for (int i = 0; i < TableSize; i++)
      if (eq && tlen(i) == 2 && tchar(i, 0) == c && tchar(i, 1) == "=") k = 6'(TK_TABLE + i);
      else if (!eq && tlen(i) == 1 && tchar(i, 0) == c) k = 6'(TK_TABLE + i);
    lookup_op = k;
  endfunction

  logic [5:0] word_kind;
  always_comb begin
    word_kind = TK_IDENT;
    for (int i = 0; i < TableSize; i++) begin
      logic hit;
      hit = (32'(length_count) == tlen(i)) && (tlen(i) <= KEYWORD_MAX_LEN);
      for (int p = 0; p < TableLen; p++)
        if (p < tlen(i) && p < KEYWORD_MAX_LEN) hit = hit && (word_prefix[p] == tchar(i, p));
      if (hit) word_kind = 6'(TK_TABLE + i);
    end
  end

  assign len_sat = out_len(length_count);

  always_comb begin
    logic [7:0] c;
    char_class_t cl;
    logic do_idle;
    logic [7:0] ic;
    logic [7:0] q;
    logic [LENGTH_BITS-1:0] lc;
    c  = q_item.ch;
    cl = q_item.cls;
    scan_mode_next = scan_mode;
    pending_operator_next = pending_operator;
    line_count_next = line_count;
    nesting_depth_next = nesting_depth;
    interpolation_depth_next = interpolation_depth;
    in_interpolation_next = in_interpolation;
    open_quote_next = open_quote;
    length_count_next = length_count;
    seen_dot_next = seen_dot;
    halted_next = halted;
    nrec = 2'd0;
    for (int i = 0; i < 3; i++) rec[i] = '0;
    wp_we = 1'b0;
    wp_idx = '0;
    do_idle = 1'b0;
    ic = c;
    q = (open_quote == 2'd2) ? 8'h22 : 8'h27;
    lc = length_count;

    if (q_item.eoi) begin
      unique case (scan_mode)
        M_COMMENT: begin rec[0] = '{REC_ERROR, 8'd0, 6'd0, 12'd0, ERR_COMMENT, 1'b0};
          nrec = 2'd1; halted_next = 1'b1; end
        M_STRING, M_ESCAPE: begin
          rec[0] = '{REC_ERROR, 8'd0, 6'd0, 12'd0, ERR_STRING, 1'b0};
          nrec = 2'd1; halted_next = 1'b1; end
        M_RESUME: begin rec[0] = '{REC_ERROR, 8'd0, 6'd0, 12'd0, ERR_INTERP, 1'b0};
          nrec = 2'd1; halted_next = 1'b1; end
        default: begin
          if (scan_mode == M_WORD) begin
            rec[0] = '{REC_END, 8'd0, word_kind, len_sat, ERR_NONE, 1'b0}; nrec = 2'd1;
          end else if (scan_mode == M_NUMBER) begin
            rec[0] = '{REC_END, 8'd0, seen_dot ? TK_FLOAT : TK_INT, len_sat, ERR_NONE, 1'b0};
            nrec = 2'd1;
          end else if (scan_mode == M_OP) begin
            rec[0] = '{REC_END, 8'd0, lookup_op(pending_operator, 1'b0), 12'd1, ERR_NONE, 1'b0};
            nrec = 2'd1;
          end
          if (open_quote != 2'd0) begin
            rec[nrec] = '{REC_ERROR, 8'd0, 6'd0, 12'd0, ERR_INTERP, 1'b0};
            nrec = nrec + 2'd1; halted_next = 1'b1; scan_mode_next = M_IDLE;
          end else begin
            rec[nrec] = '{REC_END, 8'd0, TK_EOF, 12'd0, ERR_NONE, 1'b0};
            nrec = nrec + 2'd1;
            scan_mode_next = M_IDLE; pending_operator_next = '0;
            line_count_next = LINE_BITS'(1);
            nesting_depth_next = '0; interpolation_depth_next = '0;
            in_interpolation_next = 1'b0; open_quote_next = 2'd0;
            length_count_next = '0; seen_dot_next = 1'b0;
          end
        end
      endcase
    end else begin
      unique case (scan_mode)
        M_COMMENT: begin
          if (cl == CL_BAR) scan_mode_next = M_IDLE;
          else if (cl == CL_NEWLINE && line_count != LineMax) line_count_next = line_count + 1'b1;
        end
        M_WORD: begin
          if (cl == CL_ALPHA || cl == CL_DIGIT) begin
            if (32'(length_count) < KEYWORD_MAX_LEN) begin
              wp_we = 1'b1; wp_idx = PB'(length_count);
            end
            if (length_count != LenMax) length_count_next = length_count + 1'b1;
            rec[0] = '{REC_TEXT, c, 6'd0, 12'd0, ERR_NONE, 1'b0}; nrec = 2'd1;
          end else begin
            rec[0] = '{REC_END, 8'd0, word_kind, len_sat, ERR_NONE, 1'b0}; nrec = 2'd1;
            do_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (cl == CL_DOT && seen_dot) begin
            rec[0] = '{REC_ERROR, 8'd0, 6'd0, 12'd0, ERR_TWODOTS, 1'b0};
            nrec = 2'd1; halted_next = 1'b1;
          end else if (cl == CL_DIGIT || cl == CL_DOT) begin
            if (cl == CL_DOT) seen_dot_next = 1'b1;
            if (length_count != LenMax) length_count_next = length_count + 1'b1;
            rec[0] = '{REC_TEXT, c, 6'd0, 12'd0, ERR_NONE, 1'b0}; nrec = 2'd1;
          end else begin
            rec[0] = '{REC_END, 8'd0, seen_dot ? TK_FLOAT : TK_INT, len_sat, ERR_NONE, 1'b0};
            nrec = 2'd1; do_idle = 1'b1;
          end
        end
        M_OP: begin
          if (cl == CL_EQUAL) begin
            rec[0] = '{REC_TEXT, c, 6'd0, 12'd0, ERR_NONE, 1'b0};
            rec[1] = '{REC_END, 8'd0, lookup_op(pending_operator, 1'b1), 12'd2, ERR_NONE, 1'b0};
            nrec = 2'd2; scan_mode_next = M_IDLE;
          end else begin
            rec[0] = '{REC_END, 8'd0, lookup_op(pending_operator, 1'b0), 12'd1, ERR_NONE, 1'b0};
            nrec = 2'd1; do_idle = 1'b1;
          end
        end
        M_STRING, M_RESUME: begin
          scan_mode_next = M_STRING;
          if (c == q) begin
            scan_mode_next = M_IDLE; open_quote_next = 2'd0;
            if (length_count != '0) begin
              if (q == 8'h27 && length_count > 1) begin
                rec[0] = '{REC_ERROR, 8'd0, 6'd0, 12'd0, ERR_LONGCHAR, 1'b0};
                halted_next = 1'b1;
              end else
                rec[0] = '{REC_END, 8'd0, (q == 8'h22) ? TK_STRING : TK_CHAR, len_sat,
                           ERR_NONE, 1'b0};
              nrec = 2'd1;
            end
          end else if (cl == CL_NEWLINE) begin
            if (line_count != LineMax) line_count_next = line_count + 1'b1;
          end else if (c == "[" && q == 8'h22) begin
            if (length_count != '0) begin
              rec[0] = '{REC_END, 8'd0, TK_STRING, len_sat, ERR_NONE, 1'b0}; nrec = 2'd1;
            end
            in_interpolation_next = 1'b1;
            interpolation_depth_next = nesting_depth;
            do_idle = 1'b1;
          end else if (cl == CL_BSLASH) begin
            scan_mode_next = M_ESCAPE;
          end else begin
            rec[0] = '{REC_TEXT, c, 6'd0, 12'd0, ERR_NONE, 1'b0}; nrec = 2'd1;
            if (length_count != LenMax) length_count_next = length_count + 1'b1;
          end
        end
        M_ESCAPE: begin
          scan_mode_next = M_STRING;
          if (c == "n" || c == "t") begin
            rec[0] = '{REC_TEXT, (c == "n") ? 8'h0a : 8'h09, 6'd0, 12'd0, ERR_NONE, 1'b0};
            nrec = 2'd1;
            if (lc != LenMax) lc = lc + 1'b1;
          end else begin
            rec[0] = '{REC_TEXT, 8'h5c, 6'd0, 12'd0, ERR_NONE, 1'b0};
            rec[1] = '{REC_TEXT, c, 6'd0, 12'd0, ERR_NONE, 1'b0};
            nrec = 2'd2;
            if (lc != LenMax) lc = lc + 1'b1;
            if (lc != LenMax) lc = lc + 1'b1;
          end
          length_count_next = lc;
        end
        default: do_idle = 1'b1;
      endcase
    end

    // idle dispatch; uses in_interpolation_next/interpolation_depth_next set above
    if (do_idle) begin
      logic [DEPTH_BITS-1:0] nd;
      scan_mode_next = M_IDLE;
      nd = nesting_depth;
      unique case (cl)
        CL_BLANK: ;
        CL_NEWLINE: begin
          if (line_count != LineMax) line_count_next = line_count + 1'b1;
          if (nesting_depth == '0) begin
            rec[nrec] = '{REC_TEXT, ic, 6'd0, 12'd0, ERR_NONE, 1'b1};
            rec[nrec+1] = '{REC_END, 8'd0, lookup_op(ic, 1'b0), 12'd1, ERR_NONE, 1'b1};
            nrec = nrec + 2'd2;
          end
        end
        CL_BAR: scan_mode_next = M_COMMENT;
        CL_QUOTE, CL_SINGLE: begin
          if (open_quote != 2'd0) begin
            rec[nrec] = '{REC_ERROR, 8'd0, 6'd0, 12'd0, ERR_BADCHAR, 1'b0};
            nrec = nrec + 2'd1; halted_next = 1'b1;
          end else begin
            open_quote_next = (cl == CL_QUOTE) ? 2'd2 : 2'd1;
            length_count_next = '0;
            scan_mode_next = M_STRING;
          end
        end
        CL_OPEN, CL_CLOSE: begin
          if (cl == CL_OPEN) begin
            if (nd != DepthMax) nd = nd + 1'b1;
          end else if (nd != '0) nd = nd - 1'b1;
          nesting_depth_next = nd;
          rec[nrec] = '{REC_TEXT, ic, 6'd0, 12'd0, ERR_NONE, 1'b0};
          rec[nrec+1] = '{REC_END, 8'd0, lookup_op(ic, 1'b0), 12'd1, ERR_NONE, 1'b0};
          nrec = nrec + 2'd2;
          if (ic == "]" && in_interpolation_next && nd == interpolation_depth_next) begin
            in_interpolation_next = 1'b0;
            length_count_next = '0;
            scan_mode_next = M_RESUME;
          end
        end
        CL_EQUAL: begin
          rec[nrec] = '{REC_TEXT, ic, 6'd0, 12'd0, ERR_NONE, 1'b0};
          rec[nrec+1] = '{REC_END, 8'd0, lookup_op(ic, 1'b0), 12'd1, ERR_NONE, 1'b0};
          nrec = nrec + 2'd2;
        end
        CL_ARITH: begin
          rec[nrec] = '{REC_TEXT, ic, 6'd0, 12'd0, ERR_NONE, 1'b0};
          nrec = nrec + 2'd1;
          pending_operator_next = ic;
          scan_mode_next = M_OP;
        end
        CL_ALPHA: begin
          wp_we = 1'b1; wp_idx = '0;
          length_count_next = LENGTH_BITS'(1);
          rec[nrec] = '{REC_TEXT, ic, 6'd0, 12'd0, ERR_NONE, 1'b0};
          nrec = nrec + 2'd1;
          scan_mode_next = M_WORD;
        end
        CL_DIGIT: begin
          length_count_next = LENGTH_BITS'(1);
          seen_dot_next = 1'b0;
          rec[nrec] = '{REC_TEXT, ic, 6'd0, 12'd0, ERR_NONE, 1'b0};
          nrec = nrec + 2'd1;
          scan_mode_next = M_NUMBER;
        end
        default: begin
          if (ic == ":" || ic == ",") begin
            rec[nrec] = '{REC_TEXT, ic, 6'd0, 12'd0, ERR_NONE, 1'b0};
            rec[nrec+1] = '{REC_END, 8'd0, lookup_op(ic, 1'b0), 12'd1, ERR_NONE, 1'b0};
            nrec = nrec + 2'd2;
          end else begin
            rec[nrec] = '{REC_ERROR, 8'd0, 6'd0, 12'd0, ERR_BADCHAR, 1'b0};
            nrec = nrec + 2'd1; halted_next = 1'b1;
          end
        end
      endcase
    end
    line_pre = line_count;
  end

  // last result of a drain slot goes out when held_pos reaches held_n-1
  assign busy   = (held_n != 2'd0);
  assign q_take = q_valid && (!busy || (res_ready && held_pos == held_n - 2'd1));

  logic accept_live;
  assign accept_live = q_take && !halted;

  always_comb begin
    rec_t r;
    r = held[held_pos];
    res_valid = busy;
    res.record_kind  = r.rk;
    res.text_byte    = r.tb;
    res.token_kind   = r.tk;
    res.line_number  = 16'(r.sel_line ? held_line_post : held_line_pre);
    res.char_count   = r.len;
    res.error_code   = r.err;
    res.last_of_run  = (held_pos == held_n - 2'd1);
  end

  always_ff @(posedge clk) begin
    if (accept_live && wp_we) word_prefix[wp_idx] <= q_item.ch;
    if (accept_live) begin
      for (int i = 0; i < 3; i++) held[i] <= rec[i];
      held_line_pre  <= line_pre;
      held_line_post <= line_count_next;
    end
    if (rst) begin
      scan_mode <= M_IDLE; pending_operator <= '0; line_count <= LINE_BITS'(1);
      nesting_depth <= '0; interpolation_depth <= '0; in_interpolation <= 1'b0;
      open_quote <= 2'd0; length_count <= '0; seen_dot <= 1'b0; halted <= 1'b0;
      held_n <= 2'd0; held_pos <= 2'd0;
    end else begin
      if (busy && res_ready) begin
        if (held_pos == held_n - 2'd1) held_n <= 2'd0;
        else held_pos <= held_pos + 2'd1;
      end
      if (accept_live) begin
        scan_mode <= scan_mode_next; pending_operator <= pending_operator_next;
        line_count <= line_count_next; nesting_depth <= nesting_depth_next;
        interpolation_depth <= interpolation_depth_next;
        in_interpolation <= in_interpolation_next; open_quote <= open_quote_next;
        length_count <= length_count_next; seen_dot <= seen_dot_next;
        halted <= halted_next;
        held_n <= nrec; held_pos <= 2'd0;
      end
    end
  end
endmodule

// ===== rtl/core/script_language_tokenizer_core.sv =====
// Top level of the tokenizer core: front classifier, queue, back scanner.
//
//  channel  dir  payload                                   accepted when
//  src      in   source_byte, end_of_input                 valid && ready
//  res      out  record_kind .. last_of_run (result_t)     valid && ready
//
// An item enters the two-entry queue; the scanner takes it and then sends
// its zero to three records one per cycle while res is ready, taking the next
// item as the last record leaves.
// Reset clears the scan state, except the word prefix, and the queue. A stall on res backs up into
// the queue, then src. After an error the block drops every item until reset.
module script_language_tokenizer_core #(
  parameter int KEYWORD_MAX_LEN = 6,
  parameter int LENGTH_BITS     = 12,
  parameter int LINE_BITS       = 16,
  parameter int DEPTH_BITS      = 8
) (
  input logic clk,
  input logic rst,
  sltok_stream_if.sink   src,
  sltok_stream_if.source res
);
  import sltok_pkg::*;

  front_item_t q_item;
  logic q_valid, q_take;
  result_t r;

  sltok_front u_front (
    .clk, .rst,
    .in_byte (src.payload.source_byte),
    .in_eoi  (src.payload.end_of_input),
    .in_valid(src.valid),
    .in_ready(src.ready),
    .q_item, .q_valid, .q_take
  );

  sltok_back #(
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN), .LENGTH_BITS(LENGTH_BITS),
    .LINE_BITS(LINE_BITS), .DEPTH_BITS(DEPTH_BITS)
  ) u_back (
    .clk, .rst, .q_item, .q_valid, .q_take,
    .res(r), .res_valid(res.valid), .res_ready(res.ready)
  );

  assign res.payload = r;

  a_take_needs_valid: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid) else $error("queue taken while empty");
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && !res.payload.last_of_run |=> res.valid)
    else $error("run ended without last flag");
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.payload.record_kind == REC_ERROR |-> res.payload.last_of_run)
    else $error("error record not last");
endmodule
